@@ design/sha1_pkg.sv @@
// Shared constants, command and status types and round functions of the SHA-1 engine.
package sha1_pkg;

  localparam logic [159:0] H_INIT = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                     32'h10325476, 32'hC3D2E1F0};

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  localparam logic [5:0] POS_LAST = 6'd63;
  localparam logic [5:0] POS_LEN  = 6'd56;

  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [6:0] ROUND_P1   = 7'd20;
  localparam logic [6:0] ROUND_P2   = 7'd40;
  localparam logic [6:0] ROUND_P3   = 7'd60;

  localparam logic [2:0] WORD_LAST = 3'd4;
  localparam logic [2:0] LEN_LAST  = 3'd7;

  typedef enum logic [1:0] {
    PH_CH,
    PH_PAR1,
    PH_MAJ,
    PH_PAR2
  } round_phase_e;

  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } byte_src_e;

  typedef struct packed {
    logic         push;
    byte_src_e    src;
    logic         cap_len;
    logic         round;
    round_phase_e phase;
    logic         add;
    logic         load_out;
    logic         out_shift;
  } sha1_cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pos_len;
  } sha1_stat_t;

  function automatic logic [31:0] sha1_k(round_phase_e ph);
    logic [31:0] k;
    case (ph)
      PH_CH:   k = K_R0;
      PH_PAR1: k = K_R1;
      PH_MAJ:  k = K_R2;
      PH_PAR2: k = K_R3;
      default: k = K_R0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] sha1_f(round_phase_e ph, logic [31:0] b,
                                         logic [31:0] c, logic [31:0] d);
    logic [31:0] f;
    case (ph)
      PH_CH:   f = (b & c) | (~b & d);
      PH_MAJ:  f = (b & c) | (b & d) | (c & d);
      PH_PAR1: f = b ^ c ^ d;
      PH_PAR2: f = b ^ c ^ d;
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

@@ design/sha1_dpath.sv @@
// SHA-1 datapath: block window, bit count, chaining value, round logic and digest register.
module sha1_dpath
  import sha1_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_byte_i,
  input  sha1_cmd_t   cmd_i,
  output sha1_stat_t  stat_o,
  output logic [31:0] digest_word_o
);

  logic [511:0] blk_q, blk_d;
  logic [63:0]  cnt_q, cnt_d;
  logic [63:0]  len_q, len_d;
  logic [159:0] h_q, h_d;
  logic [159:0] dig_q, dig_d;
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [31:0]  a_d, b_d, c_d, d_d, e_d;
  logic [5:0]   pos;
  logic [7:0]   push_byte;
  logic [31:0]  w0, w2, w8, w13, w_mix, w_new, t_sum;

  assign pos             = cnt_q[8:3];
  assign stat_o.pos_last = (pos == POS_LAST);
  assign stat_o.pos_len  = (pos == POS_LEN);
  assign digest_word_o   = dig_q[159:128];

  // Window taps: word 0 is the oldest schedule word.
  assign w0    = blk_q[511:480];
  assign w2    = blk_q[447:416];
  assign w8    = blk_q[255:224];
  assign w13   = blk_q[95:64];
  assign w_mix = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign t_sum = {a_q[26:0], a_q[31:27]} + sha1_f(cmd_i.phase, b_q, c_q, d_q)
               + e_q + sha1_k(cmd_i.phase) + w0;

  always_comb begin
    case (cmd_i.src)
      SRC_DATA: push_byte = data_byte_i;
      SRC_PAD:  push_byte = PAD_BYTE;
      SRC_ZERO: push_byte = ZERO_BYTE;
      SRC_LEN:  push_byte = len_q[63:56];
      default:  push_byte = ZERO_BYTE;
    endcase
  end

  always_comb begin
    blk_d = blk_q;
    cnt_d = cnt_q;
    len_d = len_q;
    h_d   = h_q;
    dig_d = dig_q;
    a_d   = a_q;
    b_d   = b_q;
    c_d   = c_q;
    d_d   = d_q;
    e_d   = e_q;
    if (cmd_i.cap_len) begin
      len_d = cnt_q;
    end else if (cmd_i.push && (cmd_i.src == SRC_LEN)) begin
      len_d = {len_q[55:0], 8'h00};
    end
    if (cmd_i.push) begin
      blk_d = {blk_q[503:0], push_byte};
      cnt_d = cnt_q + 64'd8;
      // The last byte of a block: seed the working words for compression.
      if (stat_o.pos_last) begin
        a_d = h_q[159:128];
        b_d = h_q[127:96];
        c_d = h_q[95:64];
        d_d = h_q[63:32];
        e_d = h_q[31:0];
      end
    end
    if (cmd_i.round) begin
      blk_d = {blk_q[479:0], w_new};
      a_d   = t_sum;
      b_d   = a_q;
      c_d   = {b_q[1:0], b_q[31:2]};
      d_d   = c_q;
      e_d   = d_q;
    end
    if (cmd_i.add) begin
      h_d = {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
             h_q[63:32] + d_q, h_q[31:0] + e_q};
    end
    if (cmd_i.load_out) begin
      dig_d = h_q;
      h_d   = H_INIT;
      cnt_d = '0;
    end else if (cmd_i.out_shift) begin
      dig_d = {dig_q[127:0], 32'h0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q   <= H_INIT;
      cnt_q <= '0;
    end else begin
      h_q   <= h_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    len_q <= len_d;
    dig_q <= dig_d;
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    e_q   <= e_d;
  end

endmodule

@@ design/sha1_ctrl.sv @@
// SHA-1 controller: input handshake, padding sequencer, round counter and digest output.
module sha1_ctrl
  import sha1_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       has_byte_i,
  input  logic       is_last_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] word_index_o,
  output logic       last_word_o,
  input  sha1_stat_t stat_i,
  output sha1_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ZERO,
    ST_LEN,
    ST_ROUND,
    ST_ADD,
    ST_WAIT
  } state_e;

  state_e     state_q, ret_q;
  logic [6:0] rnd_q;
  logic [2:0] len_cnt_q;
  logic       out_valid_q;
  logic [2:0] idx_q;
  logic       in_acc, out_acc;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_acc       = (state_q == ST_IDLE) && in_valid_i;
  assign out_acc      = out_valid_q && !out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign word_index_o = idx_q;
  assign last_word_o  = (idx_q == WORD_LAST);

  always_comb begin
    cmd_o     = '0;
    cmd_o.src = SRC_DATA;
    if (rnd_q < ROUND_P1) begin
      cmd_o.phase = PH_CH;
    end else if (rnd_q < ROUND_P2) begin
      cmd_o.phase = PH_PAR1;
    end else if (rnd_q < ROUND_P3) begin
      cmd_o.phase = PH_MAJ;
    end else begin
      cmd_o.phase = PH_PAR2;
    end
    case (state_q)
      ST_IDLE: begin
        cmd_o.push = in_acc && has_byte_i;
      end
      ST_PAD: begin
        cmd_o.push    = 1'b1;
        cmd_o.src     = SRC_PAD;
        cmd_o.cap_len = 1'b1;
      end
      ST_ZERO: begin
        cmd_o.push = !stat_i.pos_len;
        cmd_o.src  = SRC_ZERO;
      end
      ST_LEN: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = SRC_LEN;
      end
      ST_ROUND: cmd_o.round    = 1'b1;
      ST_ADD:   cmd_o.add      = 1'b1;
      ST_WAIT:  cmd_o.load_out = !out_valid_q;
      default:  cmd_o.push     = 1'b0;
    endcase
    cmd_o.out_shift = out_acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      rnd_q       <= '0;
      len_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (has_byte_i && stat_i.pos_last) begin
              state_q <= ST_ROUND;
              ret_q   <= is_last_i ? ST_PAD : ST_IDLE;
            end else if (is_last_i) begin
              state_q <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (stat_i.pos_last) begin
            state_q <= ST_ROUND;
            ret_q   <= ST_ZERO;
          end else begin
            state_q <= ST_ZERO;
          end
        end
        ST_ZERO: begin
          if (stat_i.pos_len) begin
            state_q   <= ST_LEN;
            len_cnt_q <= '0;
          end else if (stat_i.pos_last) begin
            state_q <= ST_ROUND;
            ret_q   <= ST_ZERO;
          end
        end
        ST_LEN: begin
          len_cnt_q <= len_cnt_q + 3'd1;
          if (len_cnt_q == LEN_LAST) begin
            state_q <= ST_ROUND;
            ret_q   <= ST_WAIT;
          end
        end
        ST_ROUND: begin
          if (rnd_q == ROUND_LAST) begin
            rnd_q   <= '0;
            state_q <= ST_ADD;
          end else begin
            rnd_q <= rnd_q + 7'd1;
          end
        end
        ST_ADD: state_q <= ret_q;
        ST_WAIT: begin
          // Hold until the previous digest has drained.
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            idx_q       <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (out_acc) begin
        if (idx_q == WORD_LAST) begin
          out_valid_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 3'd1;
        end
      end
    end
  end

endmodule

@@ design/sha1_hash_engine.sv @@
// SHA-1 hash engine top level: byte request channel in, digest word channel out.
//
// Input channel (in_valid_i / in_stall_o): each request may carry one message
// byte (has_byte_i) and may end the message (is_last_i). Bytes are taken one
// per cycle while a block fills; the 64th byte of a block starts the 80-round
// compression, one round per cycle, and a final step then folds the result
// into the chaining value. in_stall_o is high while the round unit or the
// padding sequencer is busy, or while a digest waits for the output register.
// An ending request appends 0x80, zero fill and the 64-bit length one byte per
// cycle apart from the one or two compressions in between: the first digest
// word is valid after the last of them, later if the previous digest has not drained.
// Output channel (out_valid_o / out_stall_i): five 32-bit words, most
// significant first, each with word_index_o; last_word_o marks the fifth. The
// digest sits in its own register, so the next message streams in while the
// receiver stalls; only the end of that next message waits for the register.
// A stalled output word holds. Reset (rst_ni, asynchronous, active low)
// restores the initial chaining value, clears the bit count and drops any
// pending digest; the block buffer itself needs no clearing.
module sha1_hash_engine
  import sha1_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sha1_cmd_t  cmd;
  sha1_stat_t stat;

  // Sequencer: handshakes, padding order, round count, output word count.
  sha1_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .has_byte_i   (has_byte_i),
    .is_last_i    (is_last_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  // Storage and arithmetic: block window, count, chaining value, digest.
  sha1_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (data_byte_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .digest_word_o (digest_word_o)
  );

endmodule

@@ tb/sha1_digest_checker.sv @@
// Watches both channels of the SHA-1 engine, predicts each digest and compares it.
module sha1_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        is_last_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] digest_word_i,
  input  logic [2:0]  word_index_i,
  input  logic        last_word_i,
  output int          err_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [31:0] IV_E = 32'hC3D2E1F0;

  localparam logic [31:0] K_CHOOSE   = 32'h5A827999;
  localparam logic [31:0] K_PARITY_A = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJORITY = 32'h8F1BBCDC;
  localparam logic [31:0] K_PARITY_B = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LAST_SLOT  = 6'd63;
  localparam logic [5:0] LEN_SLOT   = 6'd56;
  localparam int         DIGEST_LEN = 5;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic [31:0]  chain_q [DIGEST_LEN];
  logic [7:0]   block_q [64];
  logic [63:0]  bit_cnt_q;
  digest_beat_t digest_q [$];
  int           errs;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic restart_chain();
    chain_q[0] = IV_A;
    chain_q[1] = IV_B;
    chain_q[2] = IV_C;
    chain_q[3] = IV_D;
    chain_q[4] = IV_E;
    bit_cnt_q  = '0;
  endtask

  // One full 80-round compression of the buffered block into the chain.
  task automatic compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {block_q[4*i], block_q[4*i+1], block_q[4*i+2], block_q[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rotl32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    e = chain_q[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_CHOOSE;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_PARITY_A;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJORITY;
      end else begin
        f = b ^ c ^ d;
        k = K_PARITY_B;
      end
      t = rotl32(a, 5) + f + e + k + w[r];
      e = d;
      d = c;
      c = rotl32(b, 30);
      b = a;
      a = t;
    end
    chain_q[0] += a;
    chain_q[1] += b;
    chain_q[2] += c;
    chain_q[3] += d;
    chain_q[4] += e;
  endtask

  // The fill slot is bits 8..3 of the running bit count; the count wraps at 64 bits.
  task automatic absorb_byte(input logic [7:0] v);
    logic [5:0] slot;
    slot = bit_cnt_q[8:3];
    block_q[slot] = v;
    bit_cnt_q += 64'd8;
    if (slot == LAST_SLOT)
      compress_block();
  endtask

  task automatic close_message();
    logic [63:0]  msg_bits;
    digest_beat_t beat;
    msg_bits = bit_cnt_q;
    absorb_byte(PAD_MARK);
    while (bit_cnt_q[8:3] != LEN_SLOT)
      absorb_byte(8'h00);
    for (int i = 0; i < 8; i++)
      absorb_byte(msg_bits[63 - 8*i -: 8]);
    for (int i = 0; i < DIGEST_LEN; i++) begin
      beat.word  = chain_q[i];
      beat.index = 3'(i);
      beat.last  = (i == DIGEST_LEN - 1);
      digest_q.push_back(beat);
    end
    restart_chain();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_beat_t exp_beat;
    if (!rst_ni) begin
      restart_chain();
      digest_q.delete();
      errs = 0;
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected digest word %h index %0d last %0b",
                   $time, digest_word_i, word_index_i, last_word_i);
        end else begin
          exp_beat = digest_q.pop_front();
          if (digest_word_i !== exp_beat.word) begin
            errs++;
            $display("%0t: digest_word expected %h actual %h",
                     $time, exp_beat.word, digest_word_i);
          end
          if (word_index_i !== exp_beat.index) begin
            errs++;
            $display("%0t: word_index expected %0d actual %0d",
                     $time, exp_beat.index, word_index_i);
          end
          if (last_word_i !== exp_beat.last) begin
            errs++;
            $display("%0t: last_word expected %0b actual %0b",
                     $time, exp_beat.last, last_word_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (has_byte_i)
          absorb_byte(data_byte_i);
        if (is_last_i)
          close_message();
      end
      err_count_o <= errs;
      pending_o   <= digest_q.size();
    end
  end

endmodule

@@ tb/tb_sha1_hash_engine.sv @@
// Testbench top for the SHA-1 engine: drives byte requests, stalls the digest side, gives the verdict.
module tb_sha1_hash_engine;
  timeunit 1ns;
  timeprecision 1ps;

  // Longest run of cycles with nothing accepted on either side, longer than any
  // closing request, solid receiver stall or sender gap.
  localparam int IDLE_LIMIT   = 4000;
  // Settle time after the last digest word, longer than one full padding pass.
  localparam int TAIL_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 160;
  localparam int MIN_MESSAGES = 4;

  // Message lengths around the padding and block boundaries.
  localparam int BOUNDARY_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_SOLID
  } stall_mode_e;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        has_byte  = 1'b0;
  logic        is_last   = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  int          err_count;
  int          pending;

  int          burst_left = 0;
  int          req_count  = 0;
  int          msg_count  = 0;
  int          idle_cycles = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sha1_hash_engine dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .data_byte_i   (data_byte),
    .has_byte_i    (has_byte),
    .is_last_i     (is_last),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .digest_word_o (digest_word),
    .word_index_o  (word_index),
    .last_word_o   (last_word)
  );

  sha1_digest_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .data_byte_i   (data_byte),
    .has_byte_i    (has_byte),
    .is_last_i     (is_last),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .digest_word_i (digest_word),
    .word_index_i  (word_index),
    .last_word_i   (last_word),
    .err_count_o   (err_count),
    .pending_o     (pending)
  );

  // Receiver: switch between no stall, coin-flip stall and solid stall, each
  // held for a random stretch, so stalls land on every word of a digest.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 2));
      stall_left <= $urandom_range(5, 40);
      out_stall  <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_RANDOM: out_stall <= 1'($urandom_range(0, 1));
        default:      out_stall <= 1'b1;
      endcase
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Issue one request and hold it until accepted. Between bursts drop valid
  // for a random gap; some bursts are long enough to run without any gap.
  task automatic send_req(input logic [7:0] b, input logic has, input logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 16);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    has_byte  <= has;
    is_last   <= last;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (has || last)
      req_count++;
  endtask

  // Hold the sender until every predicted digest word has come out. The first
  // edge lets the checker see the closing request before its count is read.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Send one message of random bytes with a few ignored requests mixed in.
  // Close it on the last byte or with a separate byte-less request.
  task automatic send_message(input int len);
    logic close_on_byte;
    close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0)
        send_req(8'($urandom), 1'b0, 1'b0);
      send_req(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
    end
    if (!close_on_byte)
      send_req(8'($urandom), 1'b0, 1'b1);
    msg_count++;
  endtask

  function automatic int pick_length();
    if ($urandom_range(0, 9) < 3)
      return BOUNDARY_LENS[$urandom_range(0, 7)];
    return $urandom_range(0, 20);
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: an ignored request, the empty message twice in a row, byte and
    // end together at both byte extremes, end after the byte, a short text with
    // an ignored request in the middle, and two bytes then a separate end.
    send_req(8'hA5, 1'b0, 1'b0);
    send_req(8'h5A, 1'b0, 1'b1);
    send_req(8'hFF, 1'b0, 1'b1);
    send_req(8'h00, 1'b1, 1'b1);
    send_req(8'hFF, 1'b1, 1'b1);
    send_req(8'hFF, 1'b1, 1'b0);
    send_req(8'h00, 1'b0, 1'b1);
    send_req(8'h61, 1'b1, 1'b0);
    send_req(8'h62, 1'b1, 1'b0);
    send_req(8'hC3, 1'b0, 1'b0);
    send_req(8'h63, 1'b1, 1'b1);
    send_req(8'h80, 1'b1, 1'b0);
    send_req(8'h7F, 1'b1, 1'b0);
    send_req(8'h01, 1'b0, 1'b1);

    // Pause the sender until the directed digests have all come out.
    wait_drained();

    // Random: whole messages of random content; the bit count wrap lies far
    // beyond any run length and is left to the checker's wrapping adder.
    req_count = 0;
    while (req_count < RANDOM_ITEMS || msg_count < MIN_MESSAGES) begin
      send_message(pick_length());
      if ($urandom_range(0, 9) == 0)
        wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
